[src/u8u16_pkg.sv]
package u8u16_pkg;

    // lead byte classification masks and patterns
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_PAT  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_PAT  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_PAT  = 8'hF0;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_PAT   = 8'h80;

    // code point limits
    localparam logic [20:0] MIN_TWO_BYTE   = 21'h00080;
    localparam logic [20:0] MIN_THREE_BYTE = 21'h00800;
    localparam logic [20:0] MIN_FOUR_BYTE  = 21'h10000;
    localparam logic [20:0] SURR_LOW       = 21'h0D800;
    localparam logic [20:0] SURR_HIGH      = 21'h0DFFF;
    localparam logic [20:0] MAX_POINT      = 21'h10FFFF;
    localparam logic [20:0] BMP_MAX        = 21'h0FFFF;

    // surrogate pair bases
    localparam logic [15:0] HI_SURR_BASE = 16'hD800;
    localparam logic [15:0] LO_SURR_BASE = 16'hDC00;

    // results caused by one input transaction
    typedef struct packed {
        logic [15:0] unit_hi;    // first (or only) code unit
        logic [15:0] unit_lo;    // second unit of a surrogate pair
        logic [1:0]  num_units;  // 0, 1 or 2 code units
        logic        has_status; // end-of-string verdict follows the units
        logic        status_ok;  // verdict: whole string valid
    } t_bundle;

endpackage

[src/utf8_to_utf16_validating_decoder_core.sv]
// UTF-8 to UTF-16 validating decoder. One byte of the string is taken per
// transaction, with i_end_of_string on its final byte. Each finished code
// point leaves as one UTF-16 unit, or as a surrogate pair above 0xFFFF; the
// final byte adds a status result (o_is_status) whose o_accepted says
// whether the whole string was valid. After the first error no further units
// leave for that string. o_last_result marks the final result caused by one
// input byte. The block takes one byte per cycle while o_ready is high;
// results leave one per cycle while i_ready is high, so a byte that causes
// several results holds the output until all have left. A two-entry result
// queue takes one more byte while such a burst drains; input stalls only while
// both entries are held and the head's final result is not being taken.
module utf8_to_utf16_validating_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_string,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_code_unit,
    output logic        o_is_status,
    output logic        o_accepted,
    output logic        o_last_result
);
    import u8u16_pkg::*;

    t_bundle     new_bundle;
    t_bundle     r_q [2];
    t_bundle     n_q [2];
    logic [1:0]  r_cnt, n_cnt;
    logic [1:0]  r_sub, n_sub;
    logic        take;
    logic        push;
    logic        pop;
    logic        out_fire;
    logic [1:0]  total;
    logic        is_unit;
    logic        last_of_head;
    logic        wr_idx;

    u8u16_decode u_decode (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_take          (take),
        .i_in_byte       (i_in_byte),
        .i_end_of_string (i_end_of_string),
        .o_bundle        (new_bundle)
    );

    // result selection from the head of the queue
    assign total        = r_q[0].num_units + {1'b0, r_q[0].has_status};
    assign is_unit      = r_sub < r_q[0].num_units;
    assign last_of_head = (r_sub == total - 2'd1);

    assign o_valid       = (r_cnt != 2'd0);
    assign o_code_unit   = !is_unit ? 16'd0 :
                           (r_sub == 2'd0) ? r_q[0].unit_hi : r_q[0].unit_lo;
    assign o_is_status   = !is_unit;
    assign o_accepted    = !is_unit && r_q[0].status_ok;
    assign o_last_result = last_of_head;

    // handshakes
    assign out_fire = o_valid && i_ready;
    assign pop      = out_fire && last_of_head;
    assign o_ready  = (r_cnt != 2'd2) || pop;
    assign take     = i_valid && o_ready;
    assign push     = take && ((new_bundle.num_units != 2'd0) || new_bundle.has_status);
    assign wr_idx   = 1'(r_cnt - {1'b0, pop});

    // queue and sub-result counter next state
    always_comb begin
        n_q   = r_q;
        n_cnt = r_cnt;
        n_sub = r_sub;
        if (pop) begin
            n_q[0] = r_q[1];
            n_sub  = 2'd0;
        end else if (out_fire) begin
            n_sub = r_sub + 2'd1;
        end
        if (push) begin
            n_q[wr_idx] = new_bundle;
        end
        n_cnt = r_cnt + {1'b0, push} - {1'b0, pop};
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_sub <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            r_sub <= n_sub;
        end
    end

    // queue payload
    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

endmodule

[src/u8u16_decode.sv]
module u8u16_decode (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  logic [7:0]          i_in_byte,
    input  logic                i_end_of_string,
    output u8u16_pkg::t_bundle  o_bundle
);
    import u8u16_pkg::*;

    logic [20:0] r_point, n_point;
    logic [1:0]  r_remain, n_remain;
    logic [1:0]  r_seq_len, n_seq_len;
    logic        r_failed, n_failed;

    logic        fin_en;
    logic [20:0] fin_cp;
    logic [1:0]  fin_len;
    logic        fin_bad;
    logic [20:0] shifted;
    logic [19:0] offset;
    t_bundle     bundle;

    // decode one byte against the current sequence state
    always_comb begin
        n_point   = r_point;
        n_remain  = r_remain;
        n_seq_len = r_seq_len;
        n_failed  = r_failed;
        fin_en    = 1'b0;
        fin_cp    = {13'd0, i_in_byte};
        fin_len   = 2'd0;
        shifted   = {r_point[14:0], i_in_byte[5:0]};

        if (!r_failed) begin
            if (r_remain == 2'd0) begin
                if (i_in_byte[7] == 1'b0) begin
                    fin_en = 1'b1;
                end else if ((i_in_byte & LEAD2_MASK) == LEAD2_PAT) begin
                    n_point   = {16'd0, i_in_byte[4:0]};
                    n_remain  = 2'd1;
                    n_seq_len = 2'd1;
                end else if ((i_in_byte & LEAD3_MASK) == LEAD3_PAT) begin
                    n_point   = {17'd0, i_in_byte[3:0]};
                    n_remain  = 2'd2;
                    n_seq_len = 2'd2;
                end else if ((i_in_byte & LEAD4_MASK) == LEAD4_PAT) begin
                    n_point   = {18'd0, i_in_byte[2:0]};
                    n_remain  = 2'd3;
                    n_seq_len = 2'd3;
                end else begin
                    n_failed = 1'b1;
                end
            end else if ((i_in_byte & CONT_MASK) != CONT_PAT) begin
                n_failed = 1'b1;
            end else begin
                n_remain = r_remain - 2'd1;
                if (r_remain == 2'd1) begin
                    fin_en    = 1'b1;
                    fin_cp    = shifted;
                    fin_len   = r_seq_len;
                    n_point   = '0;
                    n_seq_len = 2'd0;
                end else begin
                    n_point = shifted;
                end
            end
        end

        // overlong, surrogate, out of range and nul checks
        fin_bad = (fin_len == 2'd1 && fin_cp < MIN_TWO_BYTE) ||
                  (fin_len == 2'd2 && fin_cp < MIN_THREE_BYTE) ||
                  (fin_len == 2'd3 && fin_cp < MIN_FOUR_BYTE) ||
                  (fin_cp >= SURR_LOW && fin_cp <= SURR_HIGH) ||
                  (fin_cp > MAX_POINT) || (fin_cp == 21'd0);
        offset  = 20'(fin_cp - MIN_FOUR_BYTE);

        bundle = '0;
        if (fin_en) begin
            if (fin_bad) begin
                n_failed = 1'b1;
            end else if (fin_cp <= BMP_MAX) begin
                bundle.unit_hi   = fin_cp[15:0];
                bundle.num_units = 2'd1;
            end else begin
                bundle.unit_hi   = HI_SURR_BASE + {6'd0, offset[19:10]};
                bundle.unit_lo   = LO_SURR_BASE + {6'd0, offset[9:0]};
                bundle.num_units = 2'd2;
            end
        end

        // verdict on the final byte, then back to the start state
        if (i_end_of_string) begin
            bundle.has_status = 1'b1;
            bundle.status_ok  = !n_failed && (n_remain == 2'd0);
            n_point   = '0;
            n_remain  = 2'd0;
            n_seq_len = 2'd0;
            n_failed  = 1'b0;
        end
    end

    assign o_bundle = bundle;

    // sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point   <= '0;
            r_remain  <= 2'd0;
            r_seq_len <= 2'd0;
            r_failed  <= 1'b0;
        end else if (i_take) begin
            r_point   <= n_point;
            r_remain  <= n_remain;
            r_seq_len <= n_seq_len;
            r_failed  <= n_failed;
        end
    end

endmodule

[src/u8u16_checker.sv]
module u8u16_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_code_unit,
    input logic        o_is_status,
    input logic        o_accepted,
    input logic        o_last_result
);

    // a pending result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_code_unit) &&
                                   $stable(o_is_status)))
        else $error("result changed while stalled");

    // the verdict is always the final result of its byte
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_status) |-> (o_last_result && o_code_unit == 16'd0))
        else $error("status result not final or carries a unit");

    // units never carry the accepted flag
    a_unit_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_is_status) |-> !o_accepted)
        else $error("code unit with accepted set");

    // the remaining results of one byte follow without a gap
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_last_result) |=> o_valid)
        else $error("gap inside the results of one byte");

endmodule

bind utf8_to_utf16_validating_decoder_core u8u16_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_code_unit   (o_code_unit),
    .o_is_status   (o_is_status),
    .o_accepted    (o_accepted),
    .o_last_result (o_last_result)
);
